// File: sv/bcm_pkg.sv
// Shared types and constants of the battery cell monitor.
package bcm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CV_W     = 16;
  localparam int GAIN_W   = 20;
  localparam int CELL_W   = 10;
  localparam int MARGIN_W = 11;
  localparam int CFG_W    = 20;
  localparam int IDX_W    = 3;
  localparam int COUNT_W  = 3;
  localparam int LEVEL_W  = 2;
  localparam int LOW_W    = 4;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_VOLT_GAIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CELL_MIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_CELL_MAX    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CELL_ALARM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_NO_BATT_MRG = 3'd4;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   RST_VOLT_GAIN   = 20'd58000;
  localparam logic [CELL_W-1:0]   RST_CELL_MIN    = 10'd330;
  localparam logic [CELL_W-1:0]   RST_CELL_MAX    = 10'd420;
  localparam logic [CELL_W-1:0]   RST_CELL_ALARM  = 10'd350;
  localparam logic [MARGIN_W-1:0] RST_NO_BATT_MRG = 11'd400;

  // Alarm levels.
  localparam logic [LEVEL_W-1:0] ALARM_OK      = 2'd0;
  localparam logic [LEVEL_W-1:0] ALARM_LOW     = 2'd1;
  localparam logic [LEVEL_W-1:0] ALARM_NO_BATT = 2'd2;

  // Cell count that stands for no battery (PC or USB power).
  localparam logic [COUNT_W-1:0] NO_BATT_CELLS = 3'd2;
  localparam logic [LOW_W-1:0]   LOW_LIMIT     = 4'd10;

  typedef struct packed {
    logic [GAIN_W-1:0]   volt_gain_q16;
    logic [CELL_W-1:0]   cell_min_cv;
    logic [CELL_W-1:0]   cell_max_cv;
    logic [CELL_W-1:0]   cell_alarm_cv;
    logic [MARGIN_W-1:0] no_batt_margin_cv;
  } cfg_t;

  typedef struct packed {
    logic [CV_W-1:0]    voltage_cv;
    logic [COUNT_W-1:0] cell_count;
    logic [LEVEL_W-1:0] alarm_level;
    logic               status_changed;
  } res_t;

endpackage

// File: sv/battery_cell_monitor.sv
// Top level of the battery cell monitor.
//
// Each input word carries one raw ADC sample on sample_i and is taken at a
// rising edge where in_valid_i is high and in_stall_o is low. The sample is
// smoothed, scaled to centivolts with the Q16 gain register, and compared
// with the last voltage; a change re-runs the cell-count bands and the
// low-voltage alarm. Every input word yields exactly one output word.
// The word passes three registers (filter, scaling multiplier, output) on
// its way to the output. One word is accepted per cycle while in_stall_o
// is low; the filter recurrence feeds back through a reciprocal multiply
// by 1/11. When the receiver holds out_stall_i, one word is kept in a skid
// entry and in_stall_o rises once that entry fills; the output word is held
// stable. Reset clears the filter, the stored voltage, the low counter and
// the alarm, sets the cell count to the no-battery value and loads the
// default register values. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user writes them only while no word is in
// flight, which the block does not enforce; unknown indexes are ignored.
module battery_cell_monitor
  import bcm_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CV_W-1:0]     voltage_cv_o,
  output logic [COUNT_W-1:0]  cell_count_o,
  output logic [LEVEL_W-1:0]  alarm_level_o,
  output logic                status_changed_o
);

  cfg_t            cfg_q;
  logic            skid_full;
  logic            adv;
  logic            take;
  logic            volt_valid;
  logic [CV_W-1:0] volt;
  logic            status_en;
  res_t            res;
  res_t            out_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_gain_q16     <= RST_VOLT_GAIN;
      cfg_q.cell_min_cv       <= RST_CELL_MIN;
      cfg_q.cell_max_cv       <= RST_CELL_MAX;
      cfg_q.cell_alarm_cv     <= RST_CELL_ALARM;
      cfg_q.no_batt_margin_cv <= RST_NO_BATT_MRG;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VOLT_GAIN:   cfg_q.volt_gain_q16     <= cfg_data_i[GAIN_W-1:0];
        REG_CELL_MIN:    cfg_q.cell_min_cv       <= cfg_data_i[CELL_W-1:0];
        REG_CELL_MAX:    cfg_q.cell_max_cv       <= cfg_data_i[CELL_W-1:0];
        REG_CELL_ALARM:  cfg_q.cell_alarm_cv     <= cfg_data_i[CELL_W-1:0];
        REG_NO_BATT_MRG: cfg_q.no_batt_margin_cv <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together and freezes only once the skid
  // entry holds a word, so no result can be dropped.
  assign adv        = !skid_full;
  assign in_stall_o = skid_full;
  assign take       = in_valid_i && adv;
  assign status_en  = volt_valid && adv;

  bcm_filter #(
    .ADC_BITS(ADC_BITS)
  ) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .take_i  (take),
    .sample_i(sample_i),
    .gain_i  (cfg_q.volt_gain_q16),
    .valid_o (volt_valid),
    .volt_o  (volt)
  );

  bcm_status u_status (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (status_en),
    .volt_i(volt),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  bcm_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (status_en),
    .data_i     (res),
    .full_o     (skid_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign voltage_cv_o     = out_data.voltage_cv;
  assign cell_count_o     = out_data.cell_count;
  assign alarm_level_o    = out_data.alarm_level;
  assign status_changed_o = out_data.status_changed;

endmodule

// File: sv/bcm_filter.sv
// Smoothing filter and Q16 scaling to centivolts, two register stages.
module bcm_filter
  import bcm_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                take_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [GAIN_W-1:0]   gain_i,
  output logic                valid_o,
  output logic [CV_W-1:0]     volt_o
);

  localparam int SW     = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int SUM_W  = ADC_BITS + 4;
  localparam int DIV_SH = SUM_W + 4;
  localparam int M_W    = DIV_SH - 2;
  localparam logic [M_W-1:0] DIV_M = M_W'(((1 << DIV_SH) + 10) / 11);
  localparam int PROD_W = ADC_BITS + GAIN_W;
  localparam int SCL_W  = PROD_W - 16;

  logic [ADC_BITS-1:0]    filt_q, filt_d;
  logic                   fvalid_q;
  logic                   vvalid_q;
  logic [CV_W-1:0]        volt_q, volt_d;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W+M_W-1:0]   quot_prod;
  logic [PROD_W-1:0]      scl_prod;
  logic [SCL_W-1:0]       scl;
  logic [35:0]            scl_ext;

  // Filter: (10 * old + sample) / 11, the division done with a reciprocal
  // multiply that is exact over the whole sum range.
  always_comb begin
    sum       = SUM_W'({filt_q, 3'b000}) + SUM_W'({filt_q, 1'b0})
              + SUM_W'(sample_i[SW-1:0]);
    quot_prod = (SUM_W+M_W)'(sum) * (SUM_W+M_W)'(DIV_M);
    filt_d    = quot_prod[DIV_SH +: ADC_BITS];
  end

  always_comb begin
    scl_prod = PROD_W'(filt_q) * PROD_W'(gain_i);
    scl      = scl_prod[PROD_W-1:16];
    scl_ext  = 36'(scl);
    volt_d   = (scl_ext > 36'd65535) ? {CV_W{1'b1}} : scl_ext[CV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q   <= '0;
      fvalid_q <= 1'b0;
      vvalid_q <= 1'b0;
    end else if (adv_i) begin
      fvalid_q <= take_i;
      vvalid_q <= fvalid_q;
      if (take_i) begin
        filt_q <= filt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && fvalid_q) begin
      volt_q <= volt_d;
    end
  end

  assign valid_o = vvalid_q;
  assign volt_o  = volt_q;

endmodule

// File: sv/bcm_status.sv
// Cell-count classification and low-voltage alarm state.
module bcm_status
  import bcm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [CV_W-1:0] volt_i,
  input  cfg_t            cfg_i,
  output res_t            res_o
);

  logic [CV_W-1:0]    stored_q;
  logic [COUNT_W-1:0] cells_q, cells_d;
  logic [LOW_W-1:0]   low_q, low_d;
  logic [LEVEL_W-1:0] alarm_q, alarm_d;
  logic               changed;
  logic [16:0]        v_ext;
  logic [12:0]        min3, min4, min5, min6, max3, max4, max5, alarm_lim;
  logic               no_batt, in3, in4, in5, in6;
  logic [LOW_W-1:0]   low_inc;

  always_comb begin
    v_ext = 17'(volt_i);
    min3  = 13'(cfg_i.cell_min_cv) * 13'd3;
    min4  = 13'(cfg_i.cell_min_cv) * 13'd4;
    min5  = 13'(cfg_i.cell_min_cv) * 13'd5;
    min6  = 13'(cfg_i.cell_min_cv) * 13'd6;
    max3  = 13'(cfg_i.cell_max_cv) * 13'd3;
    max4  = 13'(cfg_i.cell_max_cv) * 13'd4;
    max5  = 13'(cfg_i.cell_max_cv) * 13'd5;

    no_batt = (v_ext + 17'(cfg_i.no_batt_margin_cv)) < 17'(min3);
    in3     = (v_ext >= 17'(min3)) && (v_ext <= 17'(max3));
    in4     = (v_ext >= 17'(min4)) && (v_ext <= 17'(max4));
    in5     = (v_ext >= 17'(min5)) && (v_ext <= 17'(max5));
    in6     = v_ext >= 17'(min6);

    // First matching band wins; between bands the count is kept.
    if (no_batt)  cells_d = NO_BATT_CELLS;
    else if (in3) cells_d = 3'd3;
    else if (in4) cells_d = 3'd4;
    else if (in5) cells_d = 3'd5;
    else if (in6) cells_d = 3'd6;
    else          cells_d = cells_q;

    alarm_lim = 13'(cells_d) * 13'(cfg_i.cell_alarm_cv);
    low_inc   = low_q + 4'd1;
    low_d     = low_q;
    alarm_d   = alarm_q;
    if (cells_d == NO_BATT_CELLS) begin
      alarm_d = ALARM_NO_BATT;
    end else if (v_ext <= 17'(alarm_lim)) begin
      // The low alarm latches on the eleventh low reading in a row.
      if (low_inc > LOW_LIMIT) begin
        low_d   = LOW_LIMIT;
        alarm_d = ALARM_LOW;
      end else begin
        low_d = low_inc;
      end
    end else begin
      low_d = '0;
      if (alarm_q == ALARM_NO_BATT) begin
        alarm_d = ALARM_OK;
      end
    end

    changed = volt_i != stored_q;

    res_o.voltage_cv     = volt_i;
    res_o.cell_count     = changed ? cells_d : cells_q;
    res_o.alarm_level    = changed ? alarm_d : alarm_q;
    res_o.status_changed = changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      cells_q  <= NO_BATT_CELLS;
      low_q    <= '0;
      alarm_q  <= ALARM_OK;
    end else if (en_i) begin
      stored_q <= volt_i;
      if (changed) begin
        cells_q <= cells_d;
        low_q   <= low_d;
        alarm_q <= alarm_d;
      end
    end
  end

endmodule

// File: sv/bcm_skid.sv
// Output register with one skid entry.
module bcm_skid
  import bcm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_free) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sim/battery_cell_monitor_tb.sv
// Self-checking testbench for the battery cell monitor: directed cases, then random traffic.
module battery_cell_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcm_pkg::*;

  // The block is built with the default converter width.
  localparam int ADC_BITS = 12;
  localparam int ADC_MAX  = (1 << ADC_BITS) - 1;

  // Register map size. Every index at or above this one is unused.
  localparam int NUM_REGS = 5;

  // Legal register maxima and the Q16 value that stands for unity gain.
  localparam int GAIN_MAX       = 1048575;
  localparam int CELL_REG_MAX   = 1000;
  localparam int MARGIN_REG_MAX = 2000;
  localparam int Q16_ONE        = 65536;
  localparam int Q16_SHIFT      = 16;
  localparam int CV_MAX         = 65535;

  // Filter weights: new = (10 * old + sample) / 11.
  localparam int FILTER_OLD_WEIGHT = 10;
  localparam int FILTER_DIV        = 11;

  // Cell counts that the band tests can produce.
  localparam int FIRST_BANDED = 3;
  localparam int LAST_BANDED  = 5;
  localparam int MAX_CELLS    = 6;

  // A word passes three register stages, and the block is idle once the last
  // result has arrived; these quiet cycles are a margin on top of that.
  localparam int PIPE_LATENCY = 4;
  localparam int MAX_GAP      = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASES       = 10;
  localparam int DRAIN_LIMIT  = 2000;
  localparam longint TIMEOUT_NS = 5_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CV_W-1:0]     voltage_cv_o;
  logic [COUNT_W-1:0]  cell_count_o;
  logic [LEVEL_W-1:0]  alarm_level_o;
  logic                status_changed_o;

  battery_cell_monitor #(
    .ADC_BITS(ADC_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .voltage_cv_o    (voltage_cv_o),
    .cell_count_o    (cell_count_o),
    .alarm_level_o   (alarm_level_o),
    .status_changed_o(status_changed_o)
  );

  // 20 ns clock period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Our own copy of the register file and of the monitor state. The
  // expected status for every accepted sample is computed from these.
  cfg_t                model_cfg;
  logic [SAMPLE_W-1:0] flt_level;
  logic [CV_W-1:0]     kept_cv;
  logic [COUNT_W-1:0]  kept_cells;
  logic [LOW_W-1:0]    low_run;
  logic [LEVEL_W-1:0]  alarm_now;

  // Expected status words, oldest first.
  res_t status_queue[$];

  int unsigned mismatch_count  = 0;
  int unsigned words_checked   = 0;
  int unsigned items_sent      = 0;
  int unsigned settings_used   = 0;
  int unsigned status_updates  = 0;
  int unsigned alarm_latches   = 0;
  int unsigned no_batt_entries = 0;

  // When set, the matching side never idles: these give stretches of
  // back-to-back traffic.
  bit steady_in  = 1'b0;
  bit steady_out = 1'b0;

  // State of the random sample generator: a slowly moving battery level.
  int          level_now = 2048;
  int          trend     = 0;
  int unsigned run_left  = 0;

  task automatic reset_model();
    model_cfg.volt_gain_q16     = RST_VOLT_GAIN;
    model_cfg.cell_min_cv       = RST_CELL_MIN;
    model_cfg.cell_max_cv       = RST_CELL_MAX;
    model_cfg.cell_alarm_cv     = RST_CELL_ALARM;
    model_cfg.no_batt_margin_cv = RST_NO_BATT_MRG;
    flt_level  = '0;
    kept_cv    = '0;
    kept_cells = NO_BATT_CELLS;
    low_run    = '0;
    alarm_now  = ALARM_OK;
  endtask

  // Advances the monitor state by one sample and returns the status word
  // that the block must report for it.
  function automatic res_t predict_status(input logic [SAMPLE_W-1:0] raw);
    res_t            r;
    int unsigned     s;
    int unsigned     v;
    int unsigned     k;
    longint unsigned scaled;
    bit              changed;
    bit              banded;
    s = raw & ADC_MAX;
    flt_level = SAMPLE_W'(((FILTER_OLD_WEIGHT * flt_level + s) / FILTER_DIV) & ADC_MAX);
    scaled = (64'(flt_level) * 64'(model_cfg.volt_gain_q16)) >> Q16_SHIFT;
    v = (scaled > CV_MAX) ? CV_MAX : int'(scaled);
    changed = (v != kept_cv);
    if (changed) begin
      kept_cv = CV_W'(v);
      status_updates++;
      // Cell count: no battery first, then the bands in rising order, the
      // first band that matches wins; outside every band the count stays.
      if (v + model_cfg.no_batt_margin_cv < FIRST_BANDED * model_cfg.cell_min_cv) begin
        kept_cells = NO_BATT_CELLS;
      end else begin
        banded = 1'b0;
        for (k = FIRST_BANDED; k <= LAST_BANDED; k++) begin
          if (!banded && v >= k * model_cfg.cell_min_cv &&
              v <= k * model_cfg.cell_max_cv) begin
            kept_cells = COUNT_W'(k);
            banded = 1'b1;
          end
        end
        if (!banded && v >= MAX_CELLS * model_cfg.cell_min_cv) begin
          kept_cells = COUNT_W'(MAX_CELLS);
        end
      end
      // Alarm: the low alarm latches on the eleventh low reading in a row
      // and only a no-battery reading or reset takes it away.
      if (kept_cells == NO_BATT_CELLS) begin
        if (alarm_now != ALARM_NO_BATT) no_batt_entries++;
        alarm_now = ALARM_NO_BATT;
      end else if (v <= int'(kept_cells) * model_cfg.cell_alarm_cv) begin
        if (low_run == LOW_LIMIT) begin
          if (alarm_now != ALARM_LOW) alarm_latches++;
          alarm_now = ALARM_LOW;
        end else begin
          low_run = low_run + 1'b1;
        end
      end else begin
        if (alarm_now == ALARM_NO_BATT) alarm_now = ALARM_OK;
        low_run = '0;
      end
    end
    r.voltage_cv     = kept_cv;
    r.cell_count     = kept_cells;
    r.alarm_level    = alarm_now;
    r.status_changed = changed;
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  task automatic check_status(input res_t got);
    res_t want;
    if (status_queue.size() == 0) begin
      flag_error($sformatf("word with nothing pending: cv=%0d cells=%0d alarm=%0d changed=%0d",
                           got.voltage_cv, got.cell_count, got.alarm_level,
                           got.status_changed));
    end else begin
      want = status_queue.pop_front();
      words_checked++;
      if (got.voltage_cv !== want.voltage_cv || got.cell_count !== want.cell_count ||
          got.alarm_level !== want.alarm_level ||
          got.status_changed !== want.status_changed) begin
        flag_error($sformatf({"word %0d: expected cv=%0d cells=%0d alarm=%0d changed=%0d,",
                              " got cv=%0d cells=%0d alarm=%0d changed=%0d"},
                             words_checked, want.voltage_cv, want.cell_count,
                             want.alarm_level, want.status_changed, got.voltage_cv,
                             got.cell_count, got.alarm_level, got.status_changed));
      end
    end
  endtask

  // Sends one sample word. The task returns at the edge that took the word,
  // so valid is only ever changed once per falling edge: it stays high when
  // the next word follows at once and drops when a gap is drawn.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = steady_in ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    status_queue.push_back(predict_status(s));
    items_sent++;
  endtask

  // Stops sending and waits until every expected word has been taken, then
  // lets the pipeline run dry so that registers can be written safely.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (status_queue.size() == 0);
    repeat (PIPE_LATENCY) @(negedge clk_i);
  endtask

  // One register write; unknown indexes leave our copy untouched.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_VOLT_GAIN:   model_cfg.volt_gain_q16     = data[GAIN_W-1:0];
      REG_CELL_MIN:    model_cfg.cell_min_cv       = data[CELL_W-1:0];
      REG_CELL_MAX:    model_cfg.cell_max_cv       = data[CELL_W-1:0];
      REG_CELL_ALARM:  model_cfg.cell_alarm_cv     = data[CELL_W-1:0];
      REG_NO_BATT_MRG: model_cfg.no_batt_margin_cv = data[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input cfg_t c);
    drain_results();
    write_reg(REG_VOLT_GAIN, CFG_W'(c.volt_gain_q16));
    write_reg(REG_CELL_MIN, CFG_W'(c.cell_min_cv));
    write_reg(REG_CELL_MAX, CFG_W'(c.cell_max_cv));
    write_reg(REG_CELL_ALARM, CFG_W'(c.cell_alarm_cv));
    write_reg(REG_NO_BATT_MRG, CFG_W'(c.no_batt_margin_cv));
    settings_used++;
  endtask

  // With the filter held still (a sample equal to the filtered value keeps
  // it), the gain is chosen so that the scaled voltage lands on the target.
  task automatic aim_voltage(input int unsigned target_cv);
    longint unsigned gain;
    drain_results();
    gain = ((64'(target_cv) << Q16_SHIFT) + flt_level - 1) / flt_level;
    write_reg(REG_VOLT_GAIN, CFG_W'(gain));
    send_sample(flt_level);
  endtask

  function automatic int clamp_adc(input int x);
    if (x < 0) return 0;
    if (x > ADC_MAX) return ADC_MAX;
    return x;
  endfunction

  // Random samples follow a battery level that holds, sags, recovers or
  // jumps for a run of words, with a little noise and the odd wild value.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      case ($urandom_range(0, 3))
        0: trend = 0;
        1: trend = -int'($urandom_range(1, 20));
        2: trend = int'($urandom_range(1, 20));
        default: begin
          level_now = $urandom_range(0, ADC_MAX);
          trend = 0;
        end
      endcase
    end
    run_left--;
    level_now = clamp_adc(level_now + trend);
    if ($urandom_range(0, 9) == 0) return SAMPLE_W'($urandom_range(0, ADC_MAX));
    return SAMPLE_W'(clamp_adc(level_now + int'($urandom_range(0, 6)) - 3));
  endfunction

  // Straight after reset a zero sample leaves the voltage at zero, so the
  // reset status is repeated without a change. Writes to unused indexes
  // come first; any effect they had would show up in the later tests.
  task automatic test_reset_state();
    for (int i = NUM_REGS; i < (1 << IDX_W); i++) write_reg(IDX_W'(i), '1);
    send_sample('0);
    send_sample('0);
  endtask

  // Every voltage below three cells' worth counts as low. A full-scale
  // sample makes the filter climb, so each word changes the voltage: the
  // alarm latches on the eleventh and holds on the twelfth. A healthy
  // reading afterwards clears the counter but not the latched alarm.
  task automatic test_low_alarm_latch();
    drain_results();
    write_reg(REG_CELL_MIN, '0);
    write_reg(REG_CELL_MAX, CFG_W'(CELL_REG_MAX));
    write_reg(REG_CELL_ALARM, CFG_W'(CELL_REG_MAX));
    repeat (int'(LOW_LIMIT) + 2) send_sample(SAMPLE_W'(ADC_MAX));
    drain_results();
    write_reg(REG_CELL_ALARM, '0);
    send_sample(SAMPLE_W'(ADC_MAX));
  endtask

  // A zero gain drops the voltage to zero, which is no battery and replaces
  // the latched alarm; unity gain then brings back a healthy reading, which
  // returns the no-battery level to ok.
  task automatic test_no_battery();
    drain_results();
    write_reg(REG_CELL_MIN, CFG_W'(CELL_REG_MAX));
    write_reg(REG_NO_BATT_MRG, '0);
    write_reg(REG_VOLT_GAIN, '0);
    send_sample(flt_level);
    drain_results();
    write_reg(REG_CELL_MIN, '0);
    write_reg(REG_VOLT_GAIN, CFG_W'(Q16_ONE));
    send_sample(flt_level);
  endtask

  // With the default bands (3: 990..1260, 4: 1320..1680, 5: 1650..2100,
  // 6: from 1980) the targets walk through each band, the gap between
  // bands where the count is kept, the overlap of four and five cells where
  // four wins, and the no-battery region.
  task automatic test_cell_bands();
    int unsigned band_targets[9];
    band_targets = '{1000, 1300, 1500, 1800, 1660, 2200, 500, 1300, 1000};
    drain_results();
    write_reg(REG_CELL_MIN, CFG_W'(RST_CELL_MIN));
    write_reg(REG_CELL_MAX, CFG_W'(RST_CELL_MAX));
    write_reg(REG_CELL_ALARM, CFG_W'(RST_CELL_ALARM));
    write_reg(REG_NO_BATT_MRG, CFG_W'(RST_NO_BATT_MRG));
    foreach (band_targets[i]) aim_voltage(band_targets[i]);
  endtask

  // Random traffic in phases, each under its own register setting: all at
  // their maxima, cell thresholds at zero with full gain, the reset values,
  // then mostly plausible pack settings with some fully random ones.
  task automatic test_random_traffic();
    cfg_t        c;
    int unsigned per_phase;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: c = '{GAIN_W'(GAIN_MAX), CELL_W'(CELL_REG_MAX), CELL_W'(CELL_REG_MAX),
                 CELL_W'(CELL_REG_MAX), MARGIN_W'(MARGIN_REG_MAX)};
        1: c = '{GAIN_W'(GAIN_MAX), '0, '0, '0, '0};
        2: c = '{RST_VOLT_GAIN, RST_CELL_MIN, RST_CELL_MAX, RST_CELL_ALARM,
                 RST_NO_BATT_MRG};
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            c.volt_gain_q16     = GAIN_W'($urandom_range(0, GAIN_MAX));
            c.cell_min_cv       = CELL_W'($urandom_range(0, CELL_REG_MAX));
            c.cell_max_cv       = CELL_W'($urandom_range(0, CELL_REG_MAX));
            c.cell_alarm_cv     = CELL_W'($urandom_range(0, CELL_REG_MAX));
            c.no_batt_margin_cv = MARGIN_W'($urandom_range(0, MARGIN_REG_MAX));
          end else begin
            c.volt_gain_q16     = GAIN_W'($urandom_range(20000, 90000));
            c.cell_min_cv       = CELL_W'($urandom_range(280, 360));
            c.cell_max_cv       = CELL_W'(c.cell_min_cv + $urandom_range(40, 120));
            c.cell_alarm_cv     = CELL_W'($urandom_range(c.cell_min_cv, c.cell_max_cv));
            c.no_batt_margin_cv = MARGIN_W'($urandom_range(0, 800));
          end
        end
      endcase
      apply_setting(c);
      // Every third phase runs flat out on both sides.
      steady_in  = (p % 3 == 2) || ($urandom_range(0, 4) == 0);
      steady_out = (p % 3 == 2) || ($urandom_range(0, 4) == 0);
      for (int i = 0; i < per_phase; i++) begin
        send_sample(next_sample());
        // Now and then the sender holds off until the block has emptied.
        if ($urandom_range(0, 63) == 0) drain_results();
      end
      steady_in  = 1'b0;
      steady_out = 1'b0;
    end
  endtask

  // Result side: draw a stall for each word, then take and check it.
  initial begin : result_checker
    res_t        got;
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = steady_out ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.voltage_cv     = voltage_cv_o;
      got.cell_count     = cell_count_o;
      got.alarm_level    = alarm_level_o;
      got.status_changed = status_changed_o;
      check_status(got);
    end
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    reset_model();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_low_alarm_latch();
    test_no_battery();
    test_cell_bands();
    test_random_traffic();

    // Let the last words come out, with a bound, then check nothing is left.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int c = 0; c < DRAIN_LIMIT && status_queue.size() != 0; c++) @(negedge clk_i);
    repeat (PIPE_LATENCY) @(negedge clk_i);
    if (status_queue.size() != 0) begin
      flag_error($sformatf("%0d expected words never arrived", status_queue.size()));
    end

    $display("Sent %0d samples under %0d register settings; %0d words checked.",
             items_sent, settings_used, words_checked);
    $display("Saw %0d voltage updates, %0d alarm latches, %0d no-battery entries, %0d errors.",
             status_updates, alarm_latches, no_batt_entries, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // A run that hangs on a handshake ends here.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d words still expected.", status_queue.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
